// ===== hw/rtl/stl_pkg.sv =====
// Shared types, constants and keyword tables for the script token lexer.
`default_nettype none

package stl_pkg;

    localparam int MAX_TOKEN_CHARS_DEF = 32;

    localparam int KW_COUNT   = 11;
    localparam int KW_MAX_LEN = 9;

    localparam logic [2:0] KIND_OP      = 3'd0;
    localparam logic [2:0] KIND_LPAREN  = 3'd1;
    localparam logic [2:0] KIND_RPAREN  = 3'd2;
    localparam logic [2:0] KIND_NUM     = 3'd3;
    localparam logic [2:0] KIND_KEYWORD = 3'd4;
    localparam logic [2:0] KIND_IDENT   = 3'd5;
    localparam logic [2:0] KIND_NEWLINE = 3'd6;
    localparam logic [2:0] KIND_END     = 3'd7;

    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    localparam int KW_LEN [KW_COUNT] = '{3, 9, 6, 8, 2, 4, 5, 8, 3, 4, 2};

    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        "for", {"on", "_action"}, "struct", "function", "if", "else",
        "while", {"for", "_each"}, "end", "then", "do"
    };

    typedef enum logic [1:0] {
        RUN_NONE = 2'd0,
        RUN_OP   = 2'd1,
        RUN_NUM  = 2'd2,
        RUN_WORD = 2'd3
    } run_class_t;

    typedef struct packed {
        logic [7:0] char_value;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] char_out;
        logic [4:0] char_position;
        logic       last_of_token;
        logic       was_truncated;
        logic       last_of_run;
    } out_item_t;

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        logic [7:0] r;
        r = '0;
        if (int'(pos) < KW_LEN[k]) begin
            r = KW_TEXT[k][8*(KW_LEN[k]-1-int'(pos)) +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stl_token_ram.sv =====
// Token text buffer: one write port and one registered read port.
`default_nettype none

module stl_token_ram #(
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/stl_out_stage.sv =====
// Output register that holds one result word until the receiver takes it.
`default_nettype none

module stl_out_stage
    import stl_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  wire out_item_t item,
    output logic           slot_free,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic      valid_reg;
    out_item_t data_reg;

    assign slot_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= item;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/stl_scan_ctrl.sv =====
// Scanner control: classifies bytes, tracks the open run and replays tokens from the buffer.
`default_nettype none

module stl_scan_ctrl
    import stl_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF,
    localparam int ADDR_W = $clog2(MAX_TOKEN_CHARS),
    localparam int LEN_W  = $clog2(MAX_TOKEN_CHARS + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   ram_we,
    output logic      [ADDR_W-1:0] ram_waddr,
    output logic      [7:0]        ram_wdata,
    output logic                   ram_re,
    output logic      [ADDR_W-1:0] ram_raddr,
    input  wire logic [7:0]        ram_rdata,
    input  wire logic              slot_free,
    output logic                   out_load,
    output out_item_t              out_item
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_SINGLE = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_START  = 2'd1,
        PEND_SINGLE = 2'd2
    } pend_t;

    function automatic logic is_op(input logic [7:0] c);
        return c inside {8'h2D, 8'h3C, 8'h3E, 8'h2B, 8'h2A, 8'h2F, 8'h5E, 8'h3D, 8'h3A};
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c inside {8'h2E, [8'h30:8'h39]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] m,
                                                    input logic [LEN_W-1:0] pos,
                                                    input logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        for (int k = 0; k < KW_COUNT; k++) begin
            r[k] = m[k] && (pos < LEN_W'(KW_LEN[k])) && (kw_char(k, pos[3:0]) == c);
        end
        return r;
    endfunction

    state_t              state_reg, state_next;
    run_class_t          class_reg, class_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic [KW_COUNT-1:0] mask_reg, mask_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic [2:0]          flush_kind_reg, flush_kind_next;
    pend_t               pend_reg, pend_next;
    run_class_t          pend_class_reg, pend_class_next;
    logic [2:0]          pend_kind_reg, pend_kind_next;
    logic [7:0]          pend_char_reg, pend_char_next;

    logic [7:0]          c;
    run_class_t          in_class;
    logic                cont;
    logic                run_open;
    logic                kw_hit;
    logic [2:0]          run_kind;
    logic                last_char;
    logic [KW_COUNT-1:0] len_eq;

    assign c        = s_data.char_value;
    assign run_open = class_reg != RUN_NONE;
    assign s_ready  = state_reg == ST_IDLE;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            len_eq[k] = len_reg == LEN_W'(KW_LEN[k]);
        end
        kw_hit = !ovf_reg && |(mask_reg & len_eq);
        case (class_reg)
            RUN_OP:   run_kind = KIND_OP;
            RUN_NUM:  run_kind = KIND_NUM;
            default:  run_kind = kw_hit ? KIND_KEYWORD : KIND_IDENT;
        endcase
        if (is_op(c)) begin
            in_class = RUN_OP;
        end else if (is_num(c)) begin
            in_class = RUN_NUM;
        end else if (is_letter(c)) begin
            in_class = RUN_WORD;
        end else begin
            in_class = RUN_NONE;
        end
        cont = (class_reg == RUN_OP && is_op(c)) ||
               (class_reg == RUN_NUM && is_num(c)) ||
               (class_reg == RUN_WORD && (is_letter(c) || c == CH_UNDERSCORE));
        last_char = idx_reg == LEN_W'(len_reg - 1'b1);
    end

    always_comb begin
        state_next      = state_reg;
        class_next      = class_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        flush_kind_next = flush_kind_reg;
        pend_next       = pend_reg;
        pend_class_next = pend_class_reg;
        pend_kind_next  = pend_kind_reg;
        pend_char_next  = pend_char_reg;
        ram_we          = 1'b0;
        ram_waddr       = len_reg[ADDR_W-1:0];
        ram_wdata       = c;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg[ADDR_W-1:0];
        out_load        = 1'b0;
        out_item        = '{token_kind: pend_kind_reg, char_out: pend_char_reg,
                            char_position: 5'd0, last_of_token: 1'b1,
                            was_truncated: 1'b0, last_of_run: 1'b1};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.end_of_text) begin
                        pend_next       = PEND_SINGLE;
                        pend_kind_next  = KIND_END;
                        pend_char_next  = 8'h00;
                        flush_kind_next = run_kind;
                        idx_next        = '0;
                        state_next      = run_open ? ST_READ : ST_SINGLE;
                    end else if (cont) begin
                        if (len_reg < LEN_W'(MAX_TOKEN_CHARS)) begin
                            ram_we    = 1'b1;
                            len_next  = len_reg + 1'b1;
                            mask_next = kw_step(mask_reg, len_reg, c);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else begin
                        pend_char_next  = c;
                        pend_class_next = in_class;
                        flush_kind_next = run_kind;
                        idx_next        = '0;
                        if (in_class != RUN_NONE) begin
                            pend_next = PEND_START;
                        end else if (c == CH_LPAREN) begin
                            pend_next      = PEND_SINGLE;
                            pend_kind_next = KIND_LPAREN;
                        end else if (c == CH_RPAREN) begin
                            pend_next      = PEND_SINGLE;
                            pend_kind_next = KIND_RPAREN;
                        end else if (c == CH_NEWLINE) begin
                            pend_next      = PEND_SINGLE;
                            pend_kind_next = KIND_NEWLINE;
                        end else begin
                            pend_next = PEND_NONE;
                        end
                        if (run_open) begin
                            state_next = ST_READ;
                        end else if (in_class != RUN_NONE) begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            class_next = in_class;
                            len_next   = LEN_W'(1);
                            ovf_next   = 1'b0;
                            mask_next  = kw_step('1, '0, c);
                        end else if (pend_next == PEND_SINGLE) begin
                            state_next = ST_SINGLE;
                        end
                    end
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_item = '{token_kind: flush_kind_reg, char_out: ram_rdata,
                                 char_position: 5'(idx_reg), last_of_token: last_char,
                                 was_truncated: ovf_reg,
                                 last_of_run: last_char && (pend_reg != PEND_SINGLE)};
                    if (last_char) begin
                        class_next = RUN_NONE;
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        if (pend_reg == PEND_START) begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = pend_char_reg;
                            class_next = pend_class_reg;
                            len_next   = LEN_W'(1);
                            mask_next  = kw_step('1, '0, pend_char_reg);
                        end
                        state_next = (pend_reg == PEND_SINGLE) ? ST_SINGLE : ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_SINGLE: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            class_reg <= RUN_NONE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            class_reg <= class_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg       <= mask_next;
        idx_reg        <= idx_next;
        flush_kind_reg <= flush_kind_next;
        pend_reg       <= pend_next;
        pend_class_reg <= pend_class_next;
        pend_kind_reg  <= pend_kind_next;
        pend_char_reg  <= pend_char_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/script_token_lexer_core.sv =====
// Top level of the script token lexer: scanner control, token buffer and output register.
//
// The s_ channel takes one source byte per word, or an end-of-text word.
// The m_ channel gives one token character per word with its kind, position
// and flags; last_of_run marks the final word caused by one input word.
// A byte that continues or opens a run is taken while the scanner stays idle
// and sends nothing, so such bytes are accepted back to back.
// A byte that ends a run replays the stored token from the token buffer:
// each character takes a buffer read state and then an emit state that
// loads the output register. A parenthesis, newline or end marker that
// ended the run is sent after the token from a state of its own.
// The buffer's single registered read port sets the pace of this replay.
// No input word is taken while a token is replayed.
// A stalled receiver holds the current output word in the output register
// and freezes the replay until it is taken.
// Reset is synchronous and active low; it closes any open run and empties
// the output register. The token buffer needs no clearing after reset.
`default_nettype none

module script_token_lexer_core
    import stl_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    localparam int ADDR_W = $clog2(MAX_TOKEN_CHARS);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              slot_free;
    logic              out_load;
    out_item_t         out_item;

    stl_scan_ctrl #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .slot_free (slot_free),
        .out_load  (out_load),
        .out_item  (out_item)
    );

    stl_token_ram #(
        .DEPTH(MAX_TOKEN_CHARS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stl_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .item      (out_item),
        .slot_free (slot_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/stl_checker.sv =====
// Port-level assertions for the script token lexer, bound to the top level.
`default_nettype none

module stl_checker
    import stl_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result word changed or dropped.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result word valid right after reset.");

    a_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind == KIND_END |->
            m_data.char_out == 8'h00 && m_data.char_position == 5'd0 &&
            m_data.last_of_token && !m_data.was_truncated && m_data.last_of_run)
        else $error("Malformed end marker.");

    a_run_ends_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_of_run |-> m_data.last_of_token)
        else $error("Run ended in the middle of a token.");

    a_single_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.token_kind == KIND_LPAREN || m_data.token_kind == KIND_RPAREN ||
                    m_data.token_kind == KIND_NEWLINE) |->
            m_data.char_position == 5'd0 && m_data.last_of_token && m_data.last_of_run)
        else $error("Single-character token spans more than one word.");

endmodule

bind script_token_lexer_core stl_checker u_stl_checker (.*);

`default_nettype wire

// ===== test/script_token_lexer_core_tb.sv =====
// Self-checking testbench for the script token lexer: directed table, random text, predictor.

module script_token_lexer_core_tb;
    import stl_pkg::*;

    localparam int TOKEN_CHARS   = MAX_TOKEN_CHARS_DEF;
    localparam int ROW_COUNT     = 24;
    localparam int RANDOM_WORDS  = 196;
    localparam int DRAIN_CYCLES  = 80;

    typedef struct {
        in_item_t  word;
        bit        typed;
        out_item_t result;
    } lex_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 64;
    int          fed_words = 0;
    int          mismatches = 0;

    out_item_t  expected_chars [$];
    out_item_t  step_chars [$];

    logic [7:0] tok_text [TOKEN_CHARS];
    int         tok_len = 0;
    run_class_t tok_class = RUN_NONE;
    bit         tok_over = 1'b0;

    string op_chars = "-<>+*/^=:";

    lex_row_t directed_rows [ROW_COUNT] = '{
        '{'{8'hA5, 1'b1}, 1'b1, '{KIND_END, 8'h00, 5'd0, 1'b1, 1'b0, 1'b1}},
        '{'{CH_LPAREN, 1'b0}, 1'b1, '{KIND_LPAREN, CH_LPAREN, 5'd0, 1'b1, 1'b0, 1'b1}},
        '{'{CH_RPAREN, 1'b0}, 1'b1, '{KIND_RPAREN, CH_RPAREN, 5'd0, 1'b1, 1'b0, 1'b1}},
        '{'{CH_NEWLINE, 1'b0}, 1'b1, '{KIND_NEWLINE, CH_NEWLINE, 5'd0, 1'b1, 1'b0, 1'b1}},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{CH_UNDERSCORE, 1'b0}, 1'b0, '0},
        '{'{8'h69, 1'b0}, 1'b0, '0},
        '{'{8'h66, 1'b0}, 1'b0, '0},
        '{'{8'h20, 1'b0}, 1'b0, '0},
        '{'{8'h78, 1'b0}, 1'b0, '0},
        '{'{CH_UNDERSCORE, 1'b0}, 1'b0, '0},
        '{'{8'h31, 1'b0}, 1'b0, '0},
        '{'{8'h2E, 1'b0}, 1'b0, '0},
        '{'{8'h2D, 1'b0}, 1'b0, '0},
        '{'{8'h3C, 1'b0}, 1'b0, '0},
        '{'{8'h3E, 1'b0}, 1'b0, '0},
        '{'{8'h2B, 1'b0}, 1'b0, '0},
        '{'{8'h2A, 1'b0}, 1'b0, '0},
        '{'{8'h2F, 1'b0}, 1'b0, '0},
        '{'{8'h5E, 1'b0}, 1'b0, '0},
        '{'{8'h3D, 1'b0}, 1'b0, '0},
        '{'{8'h3A, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b1}, 1'b0, '0}
    };

    script_token_lexer_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    function automatic bit is_op(logic [7:0] c);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < op_chars.len(); i++) begin
            if (c == op_chars[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c == 8'h2E || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic bit kw_match();
        bit hit;
        bit same;
        hit = 1'b0;
        if (!tok_over) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (KW_LEN[k] == tok_len) begin
                    same = 1'b1;
                    for (int i = 0; i < tok_len; i++) begin
                        if (tok_text[i] != kw_char(k, 4'(i))) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        hit = 1'b1;
                    end
                end
            end
        end
        return hit;
    endfunction

    function automatic void store_char(logic [7:0] c);
        if (tok_len < TOKEN_CHARS) begin
            tok_text[tok_len] = c;
            tok_len++;
        end else begin
            tok_over = 1'b1;
        end
    endfunction

    function automatic void flush_token();
        logic [2:0] kind;
        if (tok_class != RUN_NONE && tok_len != 0) begin
            if (tok_class == RUN_OP) begin
                kind = KIND_OP;
            end else if (tok_class == RUN_NUM) begin
                kind = KIND_NUM;
            end else begin
                kind = kw_match() ? KIND_KEYWORD : KIND_IDENT;
            end
            for (int i = 0; i < tok_len; i++) begin
                step_chars.push_back('{kind, tok_text[i], 5'(i), (i == tok_len - 1),
                                      tok_over, 1'b0});
            end
        end
        tok_class = RUN_NONE;
        tok_len   = 0;
        tok_over  = 1'b0;
    endfunction

    function automatic void lex_word(in_item_t w);
        logic [7:0] c;
        bit         cont;
        run_class_t start;
        out_item_t  tail;
        c = w.char_value;
        step_chars.delete();
        if (w.end_of_text) begin
            flush_token();
            step_chars.push_back('{KIND_END, 8'h00, 5'd0, 1'b1, 1'b0, 1'b0});
        end else begin
            cont = (tok_class == RUN_OP && is_op(c)) ||
                   (tok_class == RUN_NUM && is_num(c)) ||
                   (tok_class == RUN_WORD && (is_alpha(c) || c == CH_UNDERSCORE));
            if (cont) begin
                store_char(c);
            end else begin
                flush_token();
                start = is_op(c) ? RUN_OP : is_num(c) ? RUN_NUM :
                        is_alpha(c) ? RUN_WORD : RUN_NONE;
                if (start != RUN_NONE) begin
                    tok_class = start;
                    store_char(c);
                end else if (c == CH_LPAREN) begin
                    step_chars.push_back('{KIND_LPAREN, c, 5'd0, 1'b1, 1'b0, 1'b0});
                end else if (c == CH_RPAREN) begin
                    step_chars.push_back('{KIND_RPAREN, c, 5'd0, 1'b1, 1'b0, 1'b0});
                end else if (c == CH_NEWLINE) begin
                    step_chars.push_back('{KIND_NEWLINE, c, 5'd0, 1'b1, 1'b0, 1'b0});
                end
            end
        end
        if (step_chars.size() > 0) begin
            tail = step_chars[step_chars.size() - 1];
            tail.last_of_run = 1'b1;
            step_chars[step_chars.size() - 1] = tail;
        end
    endfunction

    function automatic logic [7:0] pick_letter();
        return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25))
                                 : 8'(8'h41 + $urandom_range(25));
    endfunction

    task automatic report_mismatch(string what, out_item_t want, out_item_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected kind %0d char %h pos %0d lt %b tr %b lr %b",
                     what, want.token_kind, want.char_out, want.char_position,
                     want.last_of_token, want.was_truncated, want.last_of_run);
            $display("    got kind %0d char %h pos %0d lt %b tr %b lr %b",
                     got.token_kind, got.char_out, got.char_position,
                     got.last_of_token, got.was_truncated, got.last_of_run);
        end
    endtask

    task automatic send_word(in_item_t w, bit typed = 1'b0, out_item_t fixed = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        fed_words++;
        lex_word(w);
        if (typed) begin
            expected_chars.push_back(fixed);
        end else begin
            foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
        end
    endtask

    task automatic send_char(logic [7:0] c);
        send_word({c, 1'b0});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("word with nothing expected", '0, m_data);
                end else if (m_data.token_kind    !== expected_chars[0].token_kind    ||
                             m_data.char_out      !== expected_chars[0].char_out      ||
                             m_data.char_position !== expected_chars[0].char_position ||
                             m_data.last_of_token !== expected_chars[0].last_of_token ||
                             m_data.was_truncated !== expected_chars[0].was_truncated ||
                             m_data.last_of_run   !== expected_chars[0].last_of_run) begin
                    report_mismatch("field mismatch", expected_chars[0], m_data);
                end
                if (expected_chars.size() != 0) begin
                    void'(expected_chars.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #6_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int pick;
        int len;
        int kw_idx;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].result);
        end

        while (fed_words < ROW_COUNT + RANDOM_WORDS) begin
            if (fed_words < ROW_COUNT + 90) begin
                send_idle_pct = 38;
                recv_idle_pct = 64;
            end else if (fed_words < ROW_COUNT + 160) begin
                send_idle_pct = 64;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            len  = ($urandom_range(15) == 0) ? $urandom_range(40, 30) : $urandom_range(8, 1);
            if (pick < 20) begin
                kw_idx = $urandom_range(KW_COUNT - 1);
                for (int i = 0; i < KW_LEN[kw_idx]; i++) send_char(kw_char(kw_idx, 4'(i)));
                if ($urandom_range(9) < 7) begin
                    send_char(8'h20);
                end
            end else if (pick < 38) begin
                send_char(pick_letter());
                for (int i = 1; i < len; i++) begin
                    send_char(($urandom_range(4) == 0) ? CH_UNDERSCORE : pick_letter());
                end
                if ($urandom_range(9) < 7) begin
                    send_char(8'h20);
                end
            end else if (pick < 53) begin
                for (int i = 0; i < len; i++) begin
                    send_char(($urandom_range(4) == 0) ? 8'h2E : 8'(8'h30 + $urandom_range(9)));
                end
            end else if (pick < 68) begin
                for (int i = 0; i < len; i++) send_char(op_chars[$urandom_range(8)]);
            end else if (pick < 80) begin
                case ($urandom_range(2))
                    0: begin
                        send_char(CH_LPAREN);
                    end
                    1: begin
                        send_char(CH_RPAREN);
                    end
                    default: begin
                        send_char(CH_NEWLINE);
                    end
                endcase
            end else if (pick < 90) begin
                send_char(8'($urandom_range(255)));
            end else if (pick < 95) begin
                send_char(8'h20);
            end else begin
                send_word({8'($urandom_range(255)), 1'b1});
            end
        end
        send_word({8'($urandom_range(255)), 1'b1});
        s_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
